/* hdl/rtpvp_pkg.sv */
// shared types and constants for the rtp video packetizer
// no dependencies
package rtpvp_pkg;

  localparam int FRAME_LEN_BITS = 20;
  localparam int HDR_LEN        = 13;
  localparam int HDR_IDX_BITS   = $clog2(HDR_LEN + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REG_SOURCE_ID    = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd1;
  localparam logic [1:0] REG_TS_STEP      = 2'd2;
  localparam logic [1:0] REG_PAYLOAD_KIND = 2'd3;

  localparam logic [31:0] SOURCE_ID_RESET    = 32'd0;
  localparam logic [10:0] MAX_PAYLOAD_RESET  = 11'd1200;
  localparam logic [15:0] TS_STEP_RESET      = 16'd3000;
  localparam logic [6:0]  PAYLOAD_KIND_RESET = 7'd96;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] DESC_FIRST       = 8'h10;
  localparam logic [7:0] DESC_OTHER       = 8'h00;

  // one accepted frame byte and, if it opens a packet, its header fields
  typedef struct packed {
    logic [7:0]  data;
    logic        has_hdr;
    logic        marker;
    logic        first;
    logic        pkt_end;
    logic [15:0] seq;
    logic [31:0] ts;
  } entry_t;

  typedef struct packed {
    logic [31:0] source_id;
    logic [6:0]  payload_kind;
  } hdr_cfg_t;

endpackage

/* hdl/rtpvp_front.sv */
// front end: accepts frame bytes, tracks frame and packet counts, classifies
// each byte and snapshots header fields; depends on rtpvp_pkg
module rtpvp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           payload_byte,
  input  logic [rtpvp_pkg::FRAME_LEN_BITS-1:0] frame_length,
  input  logic [10:0]                          max_payload,
  input  logic [15:0]                          ts_step,
  input  logic                                 q_full,
  output logic                                 push,
  output rtpvp_pkg::entry_t                    push_entry
);
  import rtpvp_pkg::*;

  logic [15:0]               seq;
  logic [31:0]               ts;
  logic [FRAME_LEN_BITS-1:0] left_frame;
  logic [10:0]               left_pkt;
  logic                      first;

  logic                      accept;
  logic                      frame_open;
  logic                      drop;
  logic [FRAME_LEN_BITS-1:0] frame_cur;
  logic [10:0]               pkt_cur;
  logic                      first_cur;
  logic                      has_hdr;
  logic [10:0]               mp;
  logic [FRAME_LEN_BITS-1:0] mp_ext;
  logic                      mp_smaller;
  logic [10:0]               chunk;
  logic [10:0]               pkt_after;
  logic [FRAME_LEN_BITS-1:0] frame_after;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    frame_open = (left_frame == '0);
    drop       = frame_open && (frame_length == '0);
    frame_cur  = frame_open ? frame_length : left_frame;
    pkt_cur    = frame_open ? 11'd0 : left_pkt;
    first_cur  = frame_open ? 1'b1 : first;
    has_hdr    = (pkt_cur == 11'd0);
    // zero max_payload behaves as one
    mp         = (max_payload == 11'd0) ? 11'd1 : max_payload;
    mp_ext     = FRAME_LEN_BITS'(mp);
    mp_smaller = (mp_ext < frame_cur);
    chunk      = mp_smaller ? mp : frame_cur[10:0];
    pkt_after  = (has_hdr ? chunk : pkt_cur) - 11'd1;
    frame_after = frame_cur - FRAME_LEN_BITS'(1);
  end

  assign push = accept && !drop;

  always_comb begin
    push_entry.data    = payload_byte;
    push_entry.has_hdr = has_hdr;
    push_entry.marker  = !mp_smaller;
    push_entry.first   = first_cur;
    push_entry.pkt_end = (pkt_after == 11'd0);
    push_entry.seq     = seq;
    push_entry.ts      = ts;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= '0;
      ts         <= '0;
      left_frame <= '0;
      left_pkt   <= '0;
      first      <= 1'b1;
    end else if (push) begin
      if (has_hdr) begin
        seq <= seq + 16'd1;
      end
      left_frame <= frame_after;
      if (frame_after == '0) begin
        ts       <= ts + 32'(ts_step);
        left_pkt <= '0;
        first    <= 1'b1;
      end else begin
        left_pkt <= pkt_after;
        first    <= has_hdr ? 1'b0 : first_cur;
      end
    end
  end

endmodule

/* hdl/rtpvp_queue.sv */
// short fifo of classified bytes between front and back ends
// depends on rtpvp_pkg
module rtpvp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rtpvp_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output rtpvp_pkg::entry_t head
);
  import rtpvp_pkg::*;

  entry_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wptr;
  logic [QUEUE_PTR_BITS-1:0] rptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full       = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rptr <= rptr + QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_BITS'(1);
        2'b01:   count <= count - QUEUE_CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/rtpvp_back.sv */
// back end: expands queued bytes into header and payload results through
// an output register; depends on rtpvp_pkg
module rtpvp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  rtpvp_pkg::entry_t   head,
  input  rtpvp_pkg::hdr_cfg_t hdr_cfg,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                packet_start,
  output logic                packet_end,
  output logic                run_last
);
  import rtpvp_pkg::*;

  logic [HDR_IDX_BITS-1:0] idx;
  logic                    load;
  logic                    emit;
  logic                    hdr_phase;
  logic [7:0]              hdr_bytes [HDR_LEN];

  assign load      = !out_valid || out_ready;
  assign emit      = head_valid && load;
  assign hdr_phase = head.has_hdr && (idx != HDR_IDX_BITS'(HDR_LEN));
  assign pop       = emit && !hdr_phase;

  always_comb begin
    hdr_bytes[0]  = RTP_VERSION_BYTE;
    hdr_bytes[1]  = {head.marker, hdr_cfg.payload_kind};
    hdr_bytes[2]  = head.seq[15:8];
    hdr_bytes[3]  = head.seq[7:0];
    hdr_bytes[4]  = head.ts[31:24];
    hdr_bytes[5]  = head.ts[23:16];
    hdr_bytes[6]  = head.ts[15:8];
    hdr_bytes[7]  = head.ts[7:0];
    hdr_bytes[8]  = hdr_cfg.source_id[31:24];
    hdr_bytes[9]  = hdr_cfg.source_id[23:16];
    hdr_bytes[10] = hdr_cfg.source_id[15:8];
    hdr_bytes[11] = hdr_cfg.source_id[7:0];
    hdr_bytes[12] = head.first ? DESC_FIRST : DESC_OTHER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= hdr_phase ? idx + HDR_IDX_BITS'(1) : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte     <= hdr_phase ? hdr_bytes[idx] : head.data;
      packet_start <= hdr_phase && (idx == '0);
      packet_end   <= !hdr_phase && head.pkt_end;
      run_last     <= !hdr_phase;
    end
  end

  // a header is always followed by its payload byte
  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_start |-> !run_last)
    else $error("packet start flagged on a last result");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= HDR_IDX_BITS'(HDR_LEN))
    else $error("header index out of range");

  a_idx_needs_hdr: assert property (@(posedge clk) disable iff (rst)
    head_valid && (idx != '0) |-> head.has_hdr)
    else $error("header index running on a payload-only entry");

  a_pop_resets_idx: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("header index not cleared after pop");

endmodule

/* hdl/rtp_video_packetizer.sv */
// top level of the rtp video packetizer: configuration registers, front end,
// queue and back end; depends on rtpvp_pkg, rtpvp_front, rtpvp_queue, rtpvp_back
//
//   channel  handshake               payload
//   in       in_valid / in_ready     payload_byte, frame_length
//   out      out_valid / out_ready   out_byte, packet_start, packet_end, run_last
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// the back end sends one result per cycle while out_ready is high, so a
// packet-opening byte occupies it for its header and its own payload byte, and
// the four-entry queue then fills and holds off input. sustained rate, while
// out_ready is high, is one byte per cycle inside a packet plus each packet header.
// synchronous reset clears counters, queue and output valid; registers take defaults.
// cfg_ready is always high.
module rtp_video_packetizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           payload_byte,
  input  logic [rtpvp_pkg::FRAME_LEN_BITS-1:0] frame_length,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 packet_start,
  output logic                                 packet_end,
  output logic                                 run_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [31:0]                          cfg_data
);
  import rtpvp_pkg::*;

  logic [31:0] source_id;
  logic [10:0] max_payload;
  logic [15:0] ts_step;
  logic [6:0]  payload_kind;

  logic        q_full;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  logic        head_valid;
  entry_t      head;
  hdr_cfg_t    hdr_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_id    <= SOURCE_ID_RESET;
      max_payload  <= MAX_PAYLOAD_RESET;
      ts_step      <= TS_STEP_RESET;
      payload_kind <= PAYLOAD_KIND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_ID:    source_id    <= cfg_data;
        REG_MAX_PAYLOAD:  max_payload  <= cfg_data[10:0];
        REG_TS_STEP:      ts_step      <= cfg_data[15:0];
        REG_PAYLOAD_KIND: payload_kind <= cfg_data[6:0];
        default:          source_id    <= source_id;
      endcase
    end
  end

  assign hdr_cfg.source_id    = source_id;
  assign hdr_cfg.payload_kind = payload_kind;

  rtpvp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .max_payload  (max_payload),
    .ts_step      (ts_step),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  rtpvp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rtpvp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .hdr_cfg      (hdr_cfg),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .packet_start (packet_start),
    .packet_end   (packet_end),
    .run_last     (run_last)
  );

endmodule
